[rtl/core/gain_phase_from_iq_defines.svh]
// ----------------------------------------------------------------------------
// gain_phase_from_iq assertion macros
// shared concurrent assertion forms, clocked on clock and quiet in reset
// ----------------------------------------------------------------------------
`ifndef GAIN_PHASE_FROM_IQ_DEFINES_SVH
`define GAIN_PHASE_FROM_IQ_DEFINES_SVH

// same-cycle implication
`define GPI_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GPI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_pkg
// constants and types shared by the gain / phase pipeline
// ----------------------------------------------------------------------------
package gpi_pkg;

   // cordic vectoring
   localparam int PRESCALE = 6;
   localparam int STEPS    = 23;
   localparam int ANGLE_W  = 25;
   localparam int ATAN_W   = 22;

   // atan(2^-k) in degrees, Q16, rounded
   localparam logic [ATAN_W-1:0] ATAN_Q16 [0:STEPS-1] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
      22'd14,      22'd7,       22'd4,      22'd2,      22'd1
   };

   localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 25'sd5898240;
   localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 25'sd11796480;

   // 1/K of the cordic, Q32
   localparam logic [31:0] INV_GAIN = 32'd2608131496;

   // 1280*log10(2), Q16
   localparam logic [24:0] DB_SCALE = 25'd25252226;

   localparam int LOG_FRAC = 20;

   // field widths
   localparam int COUNT_W    = 24;
   localparam int POINT_W    = 8;
   localparam int AMP_W      = 32;
   localparam int GAIN_W     = 16;
   localparam int PHASE_W    = 16;
   localparam int RSP_DATA_W = 2 * AMP_W + GAIN_W + PHASE_W + POINT_W;

   // sign and zero marks of one i/q pair
   typedef struct packed {
      logic neg_i;
      logic neg_q;
      logic zero;
   } vec_flags_type;

   // gain special cases
   typedef struct packed {
      logic no_signal;
      logic resp_zero;
   } gain_flags_type;

endpackage

[rtl/core/gpi_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_delay
// stallable shift line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module gpi_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   // shift on advance
   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

[rtl/core/gpi_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_cordic
// pipelined cordic vectoring, one micro-rotation per stage, then quadrant
// fixup and 1/K scaling of the magnitude
// ----------------------------------------------------------------------------
module gpi_cordic #(
   parameter int SUM_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic [SUM_WIDTH-1:0]                  abs_i,
   input  logic [SUM_WIDTH-1:0]                  abs_q,
   input  gpi_pkg::vec_flags_type                flags,
   output logic [SUM_WIDTH+5:0]                  magnitude,
   output logic signed [gpi_pkg::ANGLE_W-1:0]    angle
);

   localparam int XW    = SUM_WIDTH + 8;
   localparam int MW    = SUM_WIDTH + 6;
   localparam int AW    = gpi_pkg::ANGLE_W;
   localparam int STEPS = gpi_pkg::STEPS;
   localparam int PAD   = XW - SUM_WIDTH - gpi_pkg::PRESCALE;

   logic signed [XW-1:0]   x_ff [0:STEPS];
   logic signed [XW-1:0]   y_ff [0:STEPS];
   logic signed [AW-1:0]   z_ff [0:STEPS];
   gpi_pkg::vec_flags_type flg_ff [0:STEPS];

   logic signed [XW-1:0]   x_in [1:STEPS];
   logic signed [XW-1:0]   y_in [1:STEPS];
   logic signed [AW-1:0]   z_in [1:STEPS];

   logic signed [AW-1:0]   z_fix;
   logic [63:0]            x_ext;
   logic [63:0]            prod_hi_ff;
   logic [63:0]            prod_lo_ff;
   logic signed [AW-1:0]   ang_fix_ff;
   logic [MW-1:0]          mag_ff;
   logic signed [AW-1:0]   ang_ff;

   // micro-rotations, branch on sign of y
   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         if (!y_ff[k][XW-1]) begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + AW'(gpi_pkg::ATAN_Q16[k]);
         end else begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - AW'(gpi_pkg::ATAN_Q16[k]);
         end
      end
   end

   // rotation stages
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]   <= $signed({{PAD{1'b0}}, abs_i, {gpi_pkg::PRESCALE{1'b0}}});
         y_ff[0]   <= $signed({{PAD{1'b0}}, abs_q, {gpi_pkg::PRESCALE{1'b0}}});
         z_ff[0]   <= '0;
         flg_ff[0] <= flags;
         for (int k = 1; k <= STEPS; k++) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            z_ff[k]   <= z_in[k];
            flg_ff[k] <= flg_ff[k-1];
         end
      end
   end

   // clamp to first quadrant, then mirror by input signs
   always_comb begin
      z_fix = z_ff[STEPS];
      if (z_fix < 0) begin
         z_fix = '0;
      end
      if (z_fix > gpi_pkg::QUARTER_TURN) begin
         z_fix = gpi_pkg::QUARTER_TURN;
      end
      if (flg_ff[STEPS].neg_i) begin
         z_fix = gpi_pkg::HALF_TURN - z_fix;
      end
      if (flg_ff[STEPS].neg_q) begin
         z_fix = -z_fix;
      end
      if (flg_ff[STEPS].zero) begin
         z_fix = '0;
      end
   end

   assign x_ext = {{(64-XW){1'b0}}, x_ff[STEPS]};

   // 1/K scaling as two 32x32 partial products
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_hi_ff <= x_ext[63:32] * gpi_pkg::INV_GAIN;
         prod_lo_ff <= x_ext[31:0] * gpi_pkg::INV_GAIN;
         ang_fix_ff <= z_fix;
      end
   end

   // combine partial products
   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff <= MW'(prod_hi_ff + (prod_lo_ff >> 32));
         ang_ff <= ang_fix_ff;
      end
   end

   assign magnitude = mag_ff;
   assign angle     = ang_ff;

endmodule

[rtl/core/gpi_log.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_log
// pipelined log2 in Q20: staged leading-one normalize, then one mantissa
// squaring per stage for each fraction bit
// ----------------------------------------------------------------------------
module gpi_log #(
   parameter int IN_W = 38
) (
   input  logic                                         clock,
   input  logic                                         enable,
   input  logic [IN_W-1:0]                              value,
   output logic [$clog2(IN_W)+gpi_pkg::LOG_FRAC-1:0]    log_value
);

   localparam int NW   = (IN_W > 31) ? IN_W : 31;
   localparam int LZW  = $clog2(NW);
   localparam int EW   = $clog2(IN_W);
   localparam int FRAC = gpi_pkg::LOG_FRAC;

   logic [NW-1:0]   n_ff  [0:LZW];
   logic [LZW-1:0]  lz_ff [0:LZW];
   logic [NW-1:0]   n_in  [1:LZW];
   logic [LZW-1:0]  lz_in [1:LZW];

   logic [30:0]     m_src [0:FRAC-1];
   logic [FRAC-1:0] f_src [0:FRAC-1];
   logic [30:0]     m_in  [1:FRAC];
   logic [FRAC-1:0] f_in  [1:FRAC];
   logic [30:0]     m_ff  [1:FRAC];
   logic [FRAC-1:0] f_ff  [1:FRAC];
   logic [EW-1:0]   e_ff  [1:FRAC];

   // normalize: shift by halving powers of two while the top is clear
   always_comb begin
      int shamt;
      for (int j = 0; j < LZW; j++) begin
         shamt = 1 << (LZW - 1 - j);
         if ((n_ff[j] >> (NW - shamt)) == '0) begin
            n_in[j+1]  = n_ff[j] << shamt;
            lz_in[j+1] = lz_ff[j] + LZW'(shamt);
         end else begin
            n_in[j+1]  = n_ff[j];
            lz_in[j+1] = lz_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff[0]  <= NW'(value) << (NW - IN_W);
         lz_ff[0] <= '0;
         for (int j = 1; j <= LZW; j++) begin
            n_ff[j]  <= n_in[j];
            lz_ff[j] <= lz_in[j];
         end
      end
   end

   // mantissa squaring, one fraction bit per stage
   always_comb begin
      logic [61:0] sq;
      logic [31:0] top;
      m_src[0] = n_ff[LZW][NW-1 -: 31];
      f_src[0] = '0;
      for (int k = 1; k < FRAC; k++) begin
         m_src[k] = m_ff[k];
         f_src[k] = f_ff[k];
      end
      for (int k = 0; k < FRAC; k++) begin
         sq  = 62'(m_src[k]) * 62'(m_src[k]);
         top = sq[61:30];
         m_in[k+1] = top[31] ? top[31:1] : top[30:0];
         f_in[k+1] = {f_src[k][FRAC-2:0], top[31]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e_ff[1] <= EW'(IN_W - 1 - int'(lz_ff[LZW]));
         m_ff[1] <= m_in[1];
         f_ff[1] <= f_in[1];
         for (int k = 2; k <= FRAC; k++) begin
            e_ff[k] <= e_ff[k-1];
            m_ff[k] <= m_in[k];
            f_ff[k] <= f_in[k];
         end
      end
   end

   assign log_value = {e_ff[FRAC], f_ff[FRAC]};

endmodule

[rtl/core/gpi_gain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_gain
// gain in dB x64 from two magnitudes: log2 difference, scale, round and
// saturate, with the no-signal and zero-response cases
// ----------------------------------------------------------------------------
module gpi_gain #(
   parameter int MAG_W = 38
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [MAG_W-1:0]                    mag_stim,
   input  logic [MAG_W-1:0]                    mag_resp,
   input  logic                                count_zero,
   output logic signed [gpi_pkg::GAIN_W-1:0]   gain,
   output logic                                no_signal
);

   localparam int NW      = (MAG_W > 31) ? MAG_W : 31;
   localparam int LZW     = $clog2(NW);
   localparam int LOG_W   = $clog2(MAG_W) + gpi_pkg::LOG_FRAC;
   localparam int LOG_LAT = 1 + LZW + gpi_pkg::LOG_FRAC;
   localparam int DW      = LOG_W + 1;
   localparam int PW      = DW + 26;
   localparam int FW      = $bits(gpi_pkg::gain_flags_type);

   localparam logic signed [PW-1:0] ROUND = PW'(36'h8_0000_0000);
   localparam logic signed [PW-1:0] G_MAX = PW'(32767);
   localparam logic signed [PW-1:0] G_MIN = PW'(-32768);

   logic [LOG_W-1:0]              log_stim;
   logic [LOG_W-1:0]              log_resp;
   gpi_pkg::gain_flags_type       flg_in;
   gpi_pkg::gain_flags_type       flg_dly;
   logic [FW-1:0]                 flg_dly_bits;
   logic signed [DW-1:0]          diff_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [PW-1:0]          rounded;
   logic signed [gpi_pkg::GAIN_W-1:0] gain_ff;
   logic                          no_signal_ff;

   gpi_log #(.IN_W(MAG_W)) u_log_stim (
      .clock     (clock),
      .enable    (enable),
      .value     (mag_stim),
      .log_value (log_stim)
   );

   gpi_log #(.IN_W(MAG_W)) u_log_resp (
      .clock     (clock),
      .enable    (enable),
      .value     (mag_resp),
      .log_value (log_resp)
   );

   // special-case marks follow the log pipeline
   assign flg_in.no_signal = (mag_stim == '0) || count_zero;
   assign flg_in.resp_zero = (mag_resp == '0);

   gpi_delay #(.WIDTH(FW), .DEPTH(LOG_LAT + 2)) u_flag_dly (
      .clock  (clock),
      .enable (enable),
      .din    (flg_in),
      .dout   (flg_dly_bits)
   );

   assign flg_dly = gpi_pkg::gain_flags_type'(flg_dly_bits);

   // log difference, then dB scaling
   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff <= $signed({1'b0, log_resp}) - $signed({1'b0, log_stim});
         prod_ff <= diff_ff * $signed({1'b0, gpi_pkg::DB_SCALE});
      end
   end

   assign rounded = (prod_ff + ROUND) >>> 36;

   // round, saturate, apply special cases
   always_ff @(posedge clock) begin
      if (enable) begin
         no_signal_ff <= flg_dly.no_signal;
         priority if (flg_dly.no_signal) begin
            gain_ff <= '0;
         end else if (flg_dly.resp_zero || (rounded < G_MIN)) begin
            gain_ff <= gpi_pkg::GAIN_W'(G_MIN);
         end else if (rounded > G_MAX) begin
            gain_ff <= gpi_pkg::GAIN_W'(G_MAX);
         end else begin
            gain_ff <= gpi_pkg::GAIN_W'(rounded);
         end
      end
   end

   assign gain      = gain_ff;
   assign no_signal = no_signal_ff;

endmodule

[rtl/core/gpi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_div
// amplitude = floor((mag + 16*count) / (32*count)), saturating, through a
// restoring divider with one quotient bit per stage
// ----------------------------------------------------------------------------
module gpi_div #(
   parameter int MAG_W = 38
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [MAG_W-1:0]                  magnitude,
   input  logic [gpi_pkg::COUNT_W-1:0]       count,
   output logic [gpi_pkg::AMP_W-1:0]         amplitude
);

   localparam int QW   = gpi_pkg::AMP_W;
   localparam int CW   = gpi_pkg::COUNT_W;
   localparam int DVW  = CW + 5;
   localparam int NUMW = ((MAG_W > CW + 4) ? MAG_W : CW + 4) + 1;
   localparam int RW   = NUMW + QW;

   logic [NUMW-1:0] num;
   logic            sat;

   logic [RW-1:0]   rem_ff  [0:QW];
   logic [DVW-1:0]  den_ff  [0:QW];
   logic [QW-1:0]   quo_ff  [0:QW];
   logic            sat_ff  [0:QW];
   logic            zero_ff [0:QW];
   logic [RW-1:0]   rem_in  [1:QW];
   logic [QW-1:0]   quo_in  [1:QW];
   logic [QW-1:0]   amp_ff;

   // numerator with rounding half, overflow test against 2^32 quotient
   assign num = NUMW'(magnitude) + NUMW'({count, 4'b0000});
   assign sat = (RW'(num) >> (QW + 5)) >= RW'(count);

   // trial subtracts, msb first
   always_comb begin
      logic [RW-1:0] trial;
      int            bitpos;
      for (int j = 0; j < QW; j++) begin
         bitpos = QW - 1 - j;
         trial  = RW'(den_ff[j]) << bitpos;
         quo_in[j+1] = quo_ff[j];
         if (rem_ff[j] >= trial) begin
            rem_in[j+1]         = rem_ff[j] - trial;
            quo_in[j+1][bitpos] = 1'b1;
         end else begin
            rem_in[j+1] = rem_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= RW'(num);
         den_ff[0]  <= {count, 5'b00000};
         quo_ff[0]  <= '0;
         sat_ff[0]  <= sat;
         zero_ff[0] <= (count == '0);
         for (int j = 1; j <= QW; j++) begin
            rem_ff[j]  <= rem_in[j];
            den_ff[j]  <= den_ff[j-1];
            quo_ff[j]  <= quo_in[j];
            sat_ff[j]  <= sat_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
         end
      end
   end

   // zero count gives zero, overflow gives all ones
   always_ff @(posedge clock) begin
      if (enable) begin
         priority if (zero_ff[QW]) begin
            amp_ff <= '0;
         end else if (sat_ff[QW]) begin
            amp_ff <= '1;
         end else begin
            amp_ff <= quo_ff[QW];
         end
      end
   end

   assign amplitude = amp_ff;

endmodule

[rtl/core/gain_phase_from_iq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_phase_from_iq
// amplitudes, gain in dB and phase difference of one sweep point from the
// i/q correlation sums of stimulus and response
// ----------------------------------------------------------------------------
// throughput: one request per cycle while no result is held; the 23-step cordic, the 32-stage
//   amplitude divider and the log squaring chain are all fully pipelined
// a stalled result freezes the whole pipeline; nothing is lost or repeated
// reset is synchronous, active high, and clears all valid bits
// ----------------------------------------------------------------------------
module gain_phase_from_iq #(
   parameter int SUM_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   // request: stimulus_i, stimulus_q, response_i, response_q (SUM_WIDTH each),
   //          sample_count (24), point_index (8)
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((4*SUM_WIDTH+32+7)/8)*8-1:0]    req_tdata,

   // result: stimulus_amplitude (32), response_amplitude (32), gain_db (16),
   //         phase_delta (16), point_out (8)
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [gpi_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // result flag: no_signal
   output logic                                   rsp_tuser
);

   localparam int MW         = SUM_WIDTH + 6;
   localparam int AW         = gpi_pkg::ANGLE_W;
   localparam int CW         = gpi_pkg::COUNT_W;
   localparam int PTW        = gpi_pkg::POINT_W;
   localparam int NW         = (MW > 31) ? MW : 31;
   localparam int LZW        = $clog2(NW);
   localparam int CORDIC_LAT = gpi_pkg::STEPS + 3;
   localparam int DIV_LAT    = gpi_pkg::AMP_W + 2;
   localparam int GAIN_LAT   = 1 + LZW + gpi_pkg::LOG_FRAC + 3;
   localparam int GAIN_PAD   = DIV_LAT - GAIN_LAT;
   localparam int PIPE_LAT   = 1 + CORDIC_LAT + DIV_LAT;
   localparam int SIDE_W     = CW + PTW;
   localparam int TAIL_W     = gpi_pkg::PHASE_W + PTW;
   localparam int GTAIL_W    = gpi_pkg::GAIN_W + 1;

   function automatic logic [SUM_WIDTH-1:0] abs_sum(input logic [SUM_WIDTH-1:0] raw);
      return raw[SUM_WIDTH-1] ? -raw : raw;
   endfunction

   logic                   adv;
   logic [PIPE_LAT-1:0]    valid_ff;
   logic                   rsp_valid_ff;
   logic [gpi_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                   rsp_user_ff;

   logic [SUM_WIDTH-1:0]   stim_i, stim_q, resp_i, resp_q;
   logic [SUM_WIDTH-1:0]   s0_stim_i_ff, s0_stim_q_ff, s0_resp_i_ff, s0_resp_q_ff;
   gpi_pkg::vec_flags_type s0_stim_flg_ff, s0_resp_flg_ff;
   logic [SIDE_W-1:0]      s0_side_ff;

   logic [MW-1:0]          mag_stim, mag_resp;
   logic signed [AW-1:0]   ang_stim, ang_resp;
   logic [SIDE_W-1:0]      side_dly;
   logic [CW-1:0]          count_p1;
   logic [PTW-1:0]         point_p1;
   logic signed [AW:0]     phase_sum;
   logic [gpi_pkg::PHASE_W-1:0] phase_p1;

   logic [gpi_pkg::AMP_W-1:0]   amp_stim, amp_resp;
   logic signed [gpi_pkg::GAIN_W-1:0] gain_val;
   logic                   no_signal_val;
   logic [GTAIL_W-1:0]     gain_tail;
   logic [TAIL_W-1:0]      phase_tail;

   // global advance: everything moves unless a result is held
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // field unpacking
   assign stim_i = req_tdata[0*SUM_WIDTH +: SUM_WIDTH];
   assign stim_q = req_tdata[1*SUM_WIDTH +: SUM_WIDTH];
   assign resp_i = req_tdata[2*SUM_WIDTH +: SUM_WIDTH];
   assign resp_q = req_tdata[3*SUM_WIDTH +: SUM_WIDTH];

   // input stage: absolute values and sign marks
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_stim_i_ff         <= abs_sum(stim_i);
         s0_stim_q_ff         <= abs_sum(stim_q);
         s0_resp_i_ff         <= abs_sum(resp_i);
         s0_resp_q_ff         <= abs_sum(resp_q);
         s0_stim_flg_ff.neg_i <= stim_i[SUM_WIDTH-1];
         s0_stim_flg_ff.neg_q <= stim_q[SUM_WIDTH-1];
         s0_stim_flg_ff.zero  <= (stim_i == '0) && (stim_q == '0);
         s0_resp_flg_ff.neg_i <= resp_i[SUM_WIDTH-1];
         s0_resp_flg_ff.neg_q <= resp_q[SUM_WIDTH-1];
         s0_resp_flg_ff.zero  <= (resp_i == '0) && (resp_q == '0);
         s0_side_ff           <= req_tdata[4*SUM_WIDTH +: SIDE_W];
      end
   end

   gpi_cordic #(.SUM_WIDTH(SUM_WIDTH)) u_cordic_stim (
      .clock     (clock),
      .enable    (adv),
      .abs_i     (s0_stim_i_ff),
      .abs_q     (s0_stim_q_ff),
      .flags     (s0_stim_flg_ff),
      .magnitude (mag_stim),
      .angle     (ang_stim)
   );

   gpi_cordic #(.SUM_WIDTH(SUM_WIDTH)) u_cordic_resp (
      .clock     (clock),
      .enable    (adv),
      .abs_i     (s0_resp_i_ff),
      .abs_q     (s0_resp_q_ff),
      .flags     (s0_resp_flg_ff),
      .magnitude (mag_resp),
      .angle     (ang_resp)
   );

   gpi_delay #(.WIDTH(SIDE_W), .DEPTH(CORDIC_LAT)) u_side_dly (
      .clock  (clock),
      .enable (adv),
      .din    (s0_side_ff),
      .dout   (side_dly)
   );

   assign count_p1 = side_dly[CW-1:0];
   assign point_p1 = side_dly[CW +: PTW];

   // phase difference, rounded to degrees x64
   assign phase_sum = (AW+1)'(ang_resp) - (AW+1)'(ang_stim) + (AW+1)'(512);
   assign phase_p1  = gpi_pkg::PHASE_W'(phase_sum >>> 10);

   gpi_div #(.MAG_W(MW)) u_div_stim (
      .clock     (clock),
      .enable    (adv),
      .magnitude (mag_stim),
      .count     (count_p1),
      .amplitude (amp_stim)
   );

   gpi_div #(.MAG_W(MW)) u_div_resp (
      .clock     (clock),
      .enable    (adv),
      .magnitude (mag_resp),
      .count     (count_p1),
      .amplitude (amp_resp)
   );

   gpi_gain #(.MAG_W(MW)) u_gain (
      .clock      (clock),
      .enable     (adv),
      .mag_stim   (mag_stim),
      .mag_resp   (mag_resp),
      .count_zero (count_p1 == '0),
      .gain       (gain_val),
      .no_signal  (no_signal_val)
   );

   // line up gain with the divider
   gpi_delay #(.WIDTH(GTAIL_W), .DEPTH(GAIN_PAD)) u_gain_dly (
      .clock  (clock),
      .enable (adv),
      .din    ({no_signal_val, gain_val}),
      .dout   (gain_tail)
   );

   gpi_delay #(.WIDTH(TAIL_W), .DEPTH(DIV_LAT)) u_phase_dly (
      .clock  (clock),
      .enable (adv),
      .din    ({point_p1, phase_p1}),
      .dout   (phase_tail)
   );

   // valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {phase_tail, gain_tail[gpi_pkg::GAIN_W-1:0], amp_resp, amp_stim};
         rsp_user_ff <= gain_tail[GTAIL_W-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/core/gpi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_checker
// port-level checks on the gain / phase pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "gain_phase_from_iq_defines.svh"

module gpi_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [gpi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tuser
);

   // an empty output never blocks requests
   `GPI_ASSERT(a_idle_ready, !rsp_tvalid, req_tready, "request blocked with empty output")

   // no signal means zero gain
   `GPI_ASSERT(a_quiet_gain, rsp_tvalid && rsp_tuser, rsp_tdata[79:64] == 16'h0000, "gain set without signal")

   // phase difference stays within one turn either way
   `GPI_ASSERT(a_phase_range, rsp_tvalid, ($signed(rsp_tdata[95:80]) <= 16'sd23040) && ($signed(rsp_tdata[95:80]) >= -16'sd23040), "phase out of range")

   // a held result stays put
   `GPI_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "held result changed")

   // nothing comes out right after reset
   `GPI_ASSERT(a_reset_empty, $past(reset), !rsp_tvalid, "result valid after reset")

endmodule

bind gain_phase_from_iq gpi_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/gain_phase_from_iq_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_phase_from_iq_tb
// streams i/q sum requests through the gain / phase pipeline and compares
// each result with a bit-exact cordic, log2 and divider predictor, under
// several sender and receiver idling phases and one long receiver hold-off
// ----------------------------------------------------------------------------
module gain_phase_from_iq_tb;

   localparam int SW       = 32;
   localparam int REQ_W    = ((4*SW+32+7)/8)*8;
   localparam int LATENCY  = 62;
   localparam int WD_LIMIT = 20000;

   typedef struct packed {
      logic [7:0]  point;
      logic [23:0] count;
      logic [31:0] resp_q;
      logic [31:0] resp_i;
      logic [31:0] stim_q;
      logic [31:0] stim_i;
   } sweep_req_type;

   // laid out as {rsp_tdata, rsp_tuser}, msb first
   typedef struct packed {
      logic [7:0]  point;
      logic [15:0] phase;
      logic [15:0] gain;
      logic [31:0] resp_amp;
      logic [31:0] stim_amp;
      logic        no_sig;
   } sweep_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [gpi_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   sweep_req_type pending_reqs[$];
   sweep_rsp_type expected_pts[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int idle_run = 0;
   bit stim_done = 1'b0;

   gain_phase_from_iq #(.SUM_WIDTH(SW)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // arithmetic shift right, floor rounding
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   // cordic vectoring of one i/q pair: magnitude Q6 and angle Q16
   function automatic void vector_polar(input logic [31:0] ri, input logic [31:0] rq,
                                        output longint unsigned mag, output longint ang);
      longint unsigned ai, aq, xh, xl;
      bit ni, nq;
      longint x, y, z, xs, ys;
      ni = ri[31];
      nq = rq[31];
      ai = ni ? (64'd1 << 32) - {32'd0, ri} : {32'd0, ri};
      aq = nq ? (64'd1 << 32) - {32'd0, rq} : {32'd0, rq};
      z = 0;
      if (ai == 0 && aq == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      x = longint'(ai << gpi_pkg::PRESCALE);
      y = longint'(aq << gpi_pkg::PRESCALE);
      for (int k = 0; k < gpi_pkg::STEPS; k++) begin
         xs = floor_shr(x, k);
         ys = floor_shr(y, k);
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(gpi_pkg::ATAN_Q16[k]);
         end else begin
            x -= ys; y += xs; z -= longint'(gpi_pkg::ATAN_Q16[k]);
         end
      end
      if (z < 0) z = 0;
      if (z > 5898240) z = 5898240;
      if (ni) z = 11796480 - z;
      if (nq) z = -z;
      xh = longint'(x) >> 32;
      xl = x & 64'hFFFF_FFFF;
      mag = xh * longint'(gpi_pkg::INV_GAIN) + ((xl * longint'(gpi_pkg::INV_GAIN)) >> 32);
      ang = z;
   endfunction

   // log2 in Q20 by repeated squaring of the Q30 mantissa
   function automatic longint log2_q20(longint unsigned v);
      int e;
      longint unsigned m;
      longint frac;
      e = 63;
      frac = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
      for (int k = 0; k < gpi_pkg::LOG_FRAC; k++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(e) * (64'sd1 << gpi_pkg::LOG_FRAC) + frac;
   endfunction

   function automatic logic [31:0] amp_of(longint unsigned mag, longint unsigned cnt);
      longint unsigned a;
      if (cnt == 0) return 32'd0;
      a = (mag + 16 * cnt) / (32 * cnt);
      return (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
   endfunction

   // expected result of one sweep point
   function automatic sweep_rsp_type predict_point(sweep_req_type r);
      sweep_rsp_type p;
      longint unsigned ms, mr;
      longint as_, ar, gain, phase, d;
      vector_polar(r.stim_i, r.stim_q, ms, as_);
      vector_polar(r.resp_i, r.resp_q, mr, ar);
      p.no_sig = (ms == 0) || (r.count == 0);
      gain = 0;
      if (!p.no_sig) begin
         if (mr == 0) gain = -32768;
         else begin
            d = log2_q20(mr) - log2_q20(ms);
            gain = floor_shr(d * longint'(gpi_pkg::DB_SCALE) + (64'sd1 << 35), 36);
            if (gain > 32767) gain = 32767;
            if (gain < -32768) gain = -32768;
         end
      end
      phase = floor_shr(ar - as_ + 512, 10);
      p.stim_amp = amp_of(ms, r.count);
      p.resp_amp = amp_of(mr, r.count);
      p.gain = gain[15:0];
      p.phase = phase[15:0];
      p.point = r.point;
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic logic [31:0] rand_sum();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return $urandom_range(0, 4095) - 2048;
         4: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic sweep_req_type rand_req();
      sweep_req_type r;
      r.stim_i = rand_sum();
      r.stim_q = rand_sum();
      r.resp_i = rand_sum();
      r.resp_q = rand_sum();
      case ($urandom_range(0, 3))
         0: r.count = 24'($urandom_range(0, 3));
         1: r.count = 24'(24'hFFFFFF - $urandom_range(0, 3));
         default: r.count = 24'($urandom >> $urandom_range(8, 31));
      endcase
      r.point = 8'($urandom);
      return r;
   endfunction

   function automatic sweep_req_type mk(logic [31:0] si, logic [31:0] sq, logic [31:0] ri,
                                        logic [31:0] rq, logic [23:0] c, logic [7:0] pt);
      sweep_req_type r;
      r.stim_i = si; r.stim_q = sq; r.resp_i = ri; r.resp_q = rq;
      r.count = c; r.point = pt;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= pending_reqs[0];
            req_tvalid <= 1'b1;
            expected_pts.push_back(predict_point(pending_reqs.pop_front()));
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result sink with random stalls and a counted hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      sweep_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser};
         if (expected_pts.size() == 0) begin
            report_mismatch("unexpected result", got.point, 0);
         end else begin
            want = expected_pts.pop_front();
            if (got.stim_amp !== want.stim_amp)
               report_mismatch("stimulus_amplitude", got.stim_amp, want.stim_amp);
            if (got.resp_amp !== want.resp_amp)
               report_mismatch("response_amplitude", got.resp_amp, want.resp_amp);
            if (got.gain !== want.gain) report_mismatch("gain_db", got.gain, want.gain);
            if (got.phase !== want.phase) report_mismatch("phase_delta", got.phase, want.phase);
            if (got.point !== want.point) report_mismatch("point_out", got.point, want.point);
            if (got.no_sig !== want.no_sig)
               report_mismatch("no_signal", got.no_sig, want.no_sig);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_run <= 0;
      end else if (!stim_done || expected_pts.size() > 0) begin
         idle_run <= idle_run + 1;
         if (idle_run >= WD_LIMIT) begin
            $display("gain_phase_from_iq_tb: errors");
            $finish;
         end
      end
   end

   task automatic run_phase(int n, int sidle, int rstall);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      for (int k = 0; k < n; k++) pending_reqs.push_back(rand_req());
      while (pending_reqs.size() > 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, zero count, zero stimulus, zero response, axes
      pending_reqs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 24'hFFFFFF, 8'hFF));
      pending_reqs.push_back(mk(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 24'd1, 8'h00));
      pending_reqs.push_back(mk(100, 200, 300, 400, 24'd0, 8'h01));
      pending_reqs.push_back(mk(0, 0, 1000, -1000, 24'd10, 8'h02));
      pending_reqs.push_back(mk(5000, -5000, 0, 0, 24'd10, 8'h03));
      pending_reqs.push_back(mk(0, 0, 0, 0, 24'd0, 8'h04));
      pending_reqs.push_back(mk(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1, 8'h05));
      pending_reqs.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 24'hFFFFFF, 8'h06));
      pending_reqs.push_back(mk(-1, 0, 0, -1, 24'd1, 8'h07));
      pending_reqs.push_back(mk(0, 1, -1, 0, 24'd2, 8'h08));
      pending_reqs.push_back(mk(-1, -1, -1, 1, 24'd3, 8'hAA));
      pending_reqs.push_back(mk(1, -1, 32'h8000_0000, 1, 24'h800000, 8'h55));
      run_phase(0, 0, 0);
      run_phase(400, 0, 0);
      run_phase(350, 77, 0);
      run_phase(350, 0, 77);
      run_phase(300, 32, 32);
      // long receiver hold-off while the sender keeps offering
      hold_cycles = 300;
      run_phase(150, 0, 0);
      stim_done = 1'b1;
      while (expected_pts.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("gain_phase_from_iq_tb: clean");
      end else begin
         $display("gain_phase_from_iq_tb: errors");
      end
      $finish;
   end

endmodule
